// ----- rtl/core/smd_pkg.sv -----
package smd_pkg;

    localparam int DataW = 32;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_MODEL   = 2'd2,
        ST_ZEROVEL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MK_NMO     = 2'd0,
        MK_REFRACT = 2'd1
    } model_t;

    localparam logic [1:0] REG_MODEL = 2'd0;
    localparam logic [1:0] REG_VEL   = 2'd1;
    localparam logic [1:0] REG_T0    = 2'd2;
    localparam logic [1:0] REG_TREF  = 2'd3;

    // Control that travels beside the data in every stage
    typedef struct packed {
        logic    valid;
        logic    last;
        status_t status;
        logic    nmo;
    } ctl_t;

endpackage

// ----- rtl/core/smd_divider.sv -----
// Pipelined restoring divider: q = floor((|d| << FB) / v), one quotient bit a stage.
module smd_divider #(
    parameter int FB = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  smd_pkg::ctl_t              in_ctl,
    input  logic [31:0]                in_mag,
    input  logic [30:0]                in_vel,
    input  logic signed [31:0]         in_t0,
    output smd_pkg::ctl_t              out_ctl,
    output logic [32+FB-1:0]           out_q,
    output logic signed [31:0]         out_t0
);
    import smd_pkg::*;

    localparam int NW = 32 + FB;

    // Entry i holds the state after quotient bit i
    ctl_t              ctl_reg  [NW];
    logic [NW-1:0]     num_reg  [NW];
    logic [NW-1:0]     quo_reg  [NW];
    logic [31:0]       rem_reg  [NW];
    logic [30:0]       vel_reg  [NW];
    logic signed [31:0] t0_reg  [NW];

    for (genvar i = 0; i < NW; i++) begin : g_st
        ctl_t               ctl_in;
        logic [NW-1:0]      num_in;
        logic [NW-1:0]      quo_in;
        logic [31:0]        rem_in;
        logic [30:0]        vel_in;
        logic signed [31:0] t0_in;
        logic [32:0] trial;
        logic [31:0] rem_next;
        logic        qb;

        // Stage inputs: the ports for the first stage, else the previous stage
        if (i == 0) begin : g_first
            assign ctl_in = in_ctl;
            assign num_in = {in_mag, FB'(0)};
            assign quo_in = '0;
            assign rem_in = '0;
            assign vel_in = in_vel;
            assign t0_in  = in_t0;
        end
        else begin : g_next
            assign ctl_in = ctl_reg[i-1];
            assign num_in = num_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign vel_in = vel_reg[i-1];
            assign t0_in  = t0_reg[i-1];
        end

        always_comb
        begin
            trial    = {rem_in, num_in[NW-1-i]} - {2'b00, vel_in};
            qb       = !trial[32];
            rem_next = qb ? trial[31:0] : {rem_in[30:0], num_in[NW-1-i]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '0;
            end
            else
            begin
                ctl_reg[i] <= ctl_in;
            end
        end
        always_ff @(posedge clk)
        begin
            num_reg[i] <= num_in;
            quo_reg[i] <= {quo_in[NW-2:0], qb};
            rem_reg[i] <= rem_next;
            vel_reg[i] <= vel_in;
            t0_reg[i]  <= t0_in;
        end
    end

    assign out_ctl = ctl_reg[NW-1];
    assign out_q   = quo_reg[NW-1];
    assign out_t0  = t0_reg[NW-1];
endmodule

// ----- rtl/core/smd_sqrt.sv -----
// Pipelined integer square root of a 65-bit radicand, one result bit a stage.
module smd_sqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  smd_pkg::ctl_t     in_ctl,
    input  logic [64:0]       in_rad,
    input  logic signed [32:0] in_base,
    output smd_pkg::ctl_t     out_ctl,
    output logic [32:0]       out_root,
    output logic signed [32:0] out_base
);
    import smd_pkg::*;

    localparam int NS = 33;

    // Entry i holds the state after root bit i
    ctl_t               ctl_reg  [NS];
    logic [65:0]        rad_reg  [NS];
    logic [34:0]        rem_reg  [NS];
    logic [32:0]        root_reg [NS];
    logic signed [32:0] base_reg [NS];

    for (genvar i = 0; i < NS; i++) begin : g_st
        ctl_t               ctl_in;
        logic [65:0]        rad_in;
        logic [34:0]        rem_in;
        logic [32:0]        root_in;
        logic signed [32:0] base_in;
        logic [35:0] cur;
        logic [35:0] trial;
        logic        rb;

        // Stage inputs: the ports for the first stage, else the previous stage
        if (i == 0) begin : g_first
            assign ctl_in  = in_ctl;
            assign rad_in  = {1'b0, in_rad};
            assign rem_in  = '0;
            assign root_in = '0;
            assign base_in = in_base;
        end
        else begin : g_next
            assign ctl_in  = ctl_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign base_in = base_reg[i-1];
        end

        always_comb
        begin
            cur   = {rem_in[33:0], rad_in[65-2*i -: 2]};
            trial = cur - {1'b0, root_in, 2'b01};
            rb    = !trial[35];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '0;
            end
            else
            begin
                ctl_reg[i] <= ctl_in;
            end
        end
        always_ff @(posedge clk)
        begin
            rad_reg[i]  <= rad_in;
            rem_reg[i]  <= rb ? trial[34:0] : cur[34:0];
            root_reg[i] <= {root_in[31:0], rb};
            base_reg[i] <= base_in;
        end
    end

    assign out_ctl  = ctl_reg[NS-1];
    assign out_root = root_reg[NS-1];
    assign out_base = base_reg[NS-1];
endmodule

// ----- rtl/core/seismic_moveout_delay.sv -----
// Moveout delay engine. One distance transaction is taken every cycle (busy is
// always low); its result appears on done with delay_time, status and
// last_result, in order, after the input stage, the bit-per-stage quotient
// pipeline, the squares and sum stages, the 33-stage root pipeline and the
// output register. Results cannot be stalled. Configure only while no result
// is outstanding.
module seismic_moveout_delay #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] distance,
    input  logic               distance_missing,
    input  logic               last_trace,
    output logic               done,
    output logic signed [31:0] delay_time,
    output logic [1:0]         status,
    output logic               last_result
);
    import smd_pkg::*;

    localparam int QW = 32 + FRACTION_BITS;

    logic [1:0]         model_reg;
    logic [30:0]        vel_reg;
    logic signed [31:0] t0_reg;
    logic signed [31:0] tref_reg;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg <= 2'd0;
            vel_reg   <= 31'(1) << FRACTION_BITS;
            t0_reg    <= '0;
            tref_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_MODEL: model_reg <= pwdata[1:0];
                REG_VEL:   vel_reg   <= pwdata[30:0];
                REG_T0:    t0_reg    <= pwdata;
                REG_TREF:  tref_reg  <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MODEL: prdata = {30'd0, model_reg};
            REG_VEL:   prdata = {1'b0, vel_reg};
            REG_T0:    prdata = t0_reg;
            REG_TREF:  prdata = tref_reg;
            default:   prdata = '0;
        endcase
    end
    assign pready = 1'b1;
    assign busy   = 1'b0;

    // Input stage: classify and take magnitude
    ctl_t        s0_ctl_reg;
    logic [31:0] s0_mag_reg;
    status_t     st_next;
    ctl_t        s0_ctl_next;

    always_comb
    begin
        if (distance_missing)           st_next = ST_MISSING;
        else if (model_reg[1])          st_next = ST_MODEL;
        else if (vel_reg == '0)         st_next = ST_ZEROVEL;
        else                            st_next = ST_OK;
    end

    always_comb
    begin
        s0_ctl_next.valid  = start;
        s0_ctl_next.last   = last_trace;
        s0_ctl_next.status = st_next;
        s0_ctl_next.nmo    = (model_reg == MK_NMO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
        end
        else
        begin
            s0_ctl_reg <= s0_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_mag_reg <= distance[31] ? 32'(-distance) : 32'(distance);
    end

    ctl_t               dv_ctl;
    logic [QW-1:0]      dv_q;
    logic signed [31:0] dv_t0;

    smd_divider #(.FB(FRACTION_BITS)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (s0_ctl_reg),
        .in_mag  (s0_mag_reg),
        .in_vel  (vel_reg),
        .in_t0   (t0_reg),
        .out_ctl (dv_ctl),
        .out_q   (dv_q),
        .out_t0  (dv_t0)
    );

    // Squares stage
    ctl_t               sq_ctl_reg;
    logic [63:0]        qq_reg;
    logic [63:0]        tt_reg;
    logic               huge_reg;
    logic signed [32:0] lin_reg;
    logic [31:0]        q32;
    logic [31:0]        at;

    always_comb
    begin
        q32 = dv_q[31:0];
        at  = dv_t0[31] ? 32'(-dv_t0) : 32'(dv_t0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_ctl_reg <= '0;
        end
        else
        begin
            sq_ctl_reg <= dv_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        qq_reg   <= q32 * q32;
        tt_reg   <= at * at;
        huge_reg <= (dv_q[QW-1:32] != '0);
        lin_reg  <= 33'(tref_reg) - 33'(dv_t0);
        // For refraction the full quotient is kept in lq_reg for the difference taken in the sum stage
    end

    logic [QW-1:0] lq_reg;
    always_ff @(posedge clk)
    begin
        lq_reg <= dv_q;
    end

    // Sum stage; a sum past 2^64 matches the overflow case
    ctl_t               sm_ctl_reg;
    logic [63:0]        rad_reg;
    logic               sat_reg;
    logic signed [32:0] base_reg;
    logic signed [QW+1:0] lin_full;

    always_comb
    begin
        lin_full = (QW+2)'(lin_reg) - (QW+2)'({1'b0, lq_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_ctl_reg <= '0;
        end
        else
        begin
            sm_ctl_reg <= sq_ctl_reg;
        end
    end

    logic [64:0] sum65;
    assign sum65 = {1'b0, qq_reg} + {1'b0, tt_reg};

    logic signed [32:0] lin_sat;
    always_comb
    begin
        if (lin_full > (QW+2)'(64'sh7FFFFFFF))        lin_sat = 33'sh07FFFFFFF;
        else if (lin_full < -(QW+2)'(64'sh80000000))  lin_sat = -33'sh080000000;
        else                                           lin_sat = lin_full[32:0];
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= sum65[63:0];
        sat_reg  <= sq_ctl_reg.nmo && (huge_reg || sum65[64]);
        base_reg <= sq_ctl_reg.nmo ? 33'(tref_reg) : lin_sat;
    end

    // Root pipe; the saturation flag follows in a 33-deep delay line
    ctl_t               rt_ctl;
    logic [32:0]        rt_root;
    logic signed [32:0] rt_base;

    smd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (sm_ctl_reg),
        .in_rad   ({1'b0, rad_reg}),
        .in_base  (base_reg),
        .out_ctl  (rt_ctl),
        .out_root (rt_root),
        .out_base (rt_base)
    );

    logic [32:0] satd_reg;
    always_ff @(posedge clk)
    begin
        satd_reg <= {satd_reg[31:0], sat_reg};
    end

    // Output stage
    logic signed [34:0] diff;
    logic signed [31:0] res;

    always_comb
    begin
        diff = 35'(rt_base) - 35'({2'b00, rt_root});
        if (!rt_ctl.nmo)                      res = rt_base[31:0];
        else if (satd_reg[32])                res = 32'sh80000000;
        else if (diff > 35'sh07FFFFFFF)       res = 32'sh7FFFFFFF;
        else if (diff < -35'sh080000000)      res = 32'sh80000000;
        else                                  res = diff[31:0];
        if (rt_ctl.status != ST_OK)           res = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= rt_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        delay_time  <= res;
        status      <= rt_ctl.status;
        last_result <= rt_ctl.last;
    end
endmodule
